>>> src/ssrp_pkg.sv
package ssrp_pkg;

  // Field widths
  localparam int COORD_BITS      = 12;
  localparam int SCALE_INT_LIMIT = 8;
  localparam int SCALE_W         = 11;
  localparam int FRAC_BITS       = 8;
  localparam int TRIG_W          = 16;
  localparam int TRIG_FRAC       = 14;
  localparam int CENTER_W        = 20;
  localparam int SHIFT_W         = 16;
  localparam int OUT_W           = 17;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 20;

  // Derived datapath widths
  localparam int C_W         = COORD_BITS + 1;
  localparam int P_W         = C_W + SCALE_W;
  localparam int POS_W       = P_W - FRAC_BITS + 1;
  localparam int NRAW_W      = SCALE_W - FRAC_BITS + 1;
  localparam int CNT_W       = $clog2(SCALE_INT_LIMIT + 1);
  localparam int IDX_W       = $clog2(SCALE_INT_LIMIT);
  localparam int D_W         = ((POS_W + FRAC_BITS > CENTER_W + 1) ?
                                (POS_W + FRAC_BITS) : (CENTER_W + 1)) + 1;
  localparam int PROD_W      = D_W + TRIG_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int ROUND_SHIFT = FRAC_BITS + TRIG_FRAC;

  // Register reset values
  localparam logic [SCALE_W-1:0]        SCALE_RESET = SCALE_W'(256);
  localparam logic signed [TRIG_W-1:0]  COS_ONE     = TRIG_W'(16384);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COS      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SIN      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = CFG_IDX_W'(7);

  // Rotation multiply steps
  localparam logic [1:0] MUL_XC = 2'd0;  // acc_x = cx + dx*cos
  localparam logic [1:0] MUL_XS = 2'd1;  // acc_x -= dy*sin
  localparam logic [1:0] MUL_YS = 2'd2;  // acc_y = cy + dx*sin
  localparam logic [1:0] MUL_YC = 2'd3;  // acc_y += dy*cos

  typedef struct packed {
    logic [SCALE_W-1:0]       scale_x;
    logic [SCALE_W-1:0]       scale_y;
    logic signed [TRIG_W-1:0] cos_theta;
    logic signed [TRIG_W-1:0] sin_theta;
    logic [CENTER_W-1:0]      center_x;
    logic [CENTER_W-1:0]      center_y;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic                     rot;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       scale;
    logic       pos;
    logic       point;
    logic       mul;
    logic [1:0] mul_step;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic slot_free;
    logic rot;
  } status_t;

  // Clamp to the signed output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:OUT_W-1] == {(ACC_W-OUT_W+1){v[ACC_W-1]}});
    if (fits) begin
      return v[OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> src/ssrp_cfg_if.sv
interface ssrp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ssrp_pkg::CFG_IDX_W-1:0]   index;
  logic [ssrp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/ssrp_pixel_if.sv
interface ssrp_pixel_if;
  logic                             valid;
  logic                             ready;
  logic [ssrp_pkg::COORD_BITS-1:0]  src_x;
  logic [ssrp_pkg::COORD_BITS-1:0]  src_y;

  modport source (output valid, output src_x, output src_y, input ready);
  modport sink (input valid, input src_x, input src_y, output ready);
endinterface

>>> src/ssrp_point_if.sv
interface ssrp_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssrp_pkg::OUT_W-1:0] point_x;
  logic signed [ssrp_pkg::OUT_W-1:0] point_y;
  logic                              point_valid;
  logic                              run_end;
  logic signed [ssrp_pkg::OUT_W-1:0] moved_x;
  logic signed [ssrp_pkg::OUT_W-1:0] moved_y;

  modport source (output valid, output point_x, output point_y, output point_valid,
                  output run_end, output moved_x, output moved_y, input ready);
  modport sink (input valid, input point_x, input point_y, input point_valid,
                input run_end, input moved_x, input moved_y, output ready);
endinterface

>>> src/ssrp_cfg_regs.sv
module ssrp_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  ssrp_cfg_if.sink        cfg,
  output ssrp_pkg::cfg_t  regs
);

  logic [ssrp_pkg::SCALE_W-1:0]        scale_x;
  logic [ssrp_pkg::SCALE_W-1:0]        scale_y;
  logic signed [ssrp_pkg::TRIG_W-1:0]  cos_theta;
  logic signed [ssrp_pkg::TRIG_W-1:0]  sin_theta;
  logic [ssrp_pkg::CENTER_W-1:0]       center_x;
  logic [ssrp_pkg::CENTER_W-1:0]       center_y;
  logic signed [ssrp_pkg::SHIFT_W-1:0] shift_x;
  logic signed [ssrp_pkg::SHIFT_W-1:0] shift_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x   <= ssrp_pkg::SCALE_RESET;
      scale_y   <= ssrp_pkg::SCALE_RESET;
      cos_theta <= ssrp_pkg::COS_ONE;
      sin_theta <= '0;
      center_x  <= '0;
      center_y  <= '0;
      shift_x   <= '0;
      shift_y   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ssrp_pkg::REG_SCALE_X:  scale_x   <= cfg.data[ssrp_pkg::SCALE_W-1:0];
        ssrp_pkg::REG_SCALE_Y:  scale_y   <= cfg.data[ssrp_pkg::SCALE_W-1:0];
        ssrp_pkg::REG_COS:      cos_theta <= $signed(cfg.data[ssrp_pkg::TRIG_W-1:0]);
        ssrp_pkg::REG_SIN:      sin_theta <= $signed(cfg.data[ssrp_pkg::TRIG_W-1:0]);
        ssrp_pkg::REG_CENTER_X: center_x  <= cfg.data[ssrp_pkg::CENTER_W-1:0];
        ssrp_pkg::REG_CENTER_Y: center_y  <= cfg.data[ssrp_pkg::CENTER_W-1:0];
        ssrp_pkg::REG_SHIFT_X:  shift_x   <= $signed(cfg.data[ssrp_pkg::SHIFT_W-1:0]);
        ssrp_pkg::REG_SHIFT_Y:  shift_y   <= $signed(cfg.data[ssrp_pkg::SHIFT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    regs.scale_x   = scale_x;
    regs.scale_y   = scale_y;
    regs.cos_theta = cos_theta;
    regs.sin_theta = sin_theta;
    regs.center_x  = center_x;
    regs.center_y  = center_y;
    regs.shift_x   = shift_x;
    regs.shift_y   = shift_y;
    // identity angle leaves points unrotated
    regs.rot       = !(sin_theta == '0 && cos_theta == ssrp_pkg::COS_ONE);
  end

endmodule

>>> src/ssrp_ctrl.sv
module ssrp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  ssrp_pkg::status_t  status,
  output ssrp_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_PT    = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] step;
  logic [1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= ssrp_pkg::MUL_XC;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    cmd         = '0;
    state_next  = state;
    step_next   = step;
    pixel_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_POS;
      end
      S_POS: begin
        cmd.pos    = 1'b1;
        state_next = S_PT;
      end
      S_PT: begin
        if (status.empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.point = 1'b1;
          if (status.rot) begin
            state_next = S_MUL;
            step_next  = ssrp_pkg::MUL_XC;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_MUL: begin
        cmd.mul      = 1'b1;
        cmd.mul_step = step;
        step_next    = step + 2'd1;
        if (step == ssrp_pkg::MUL_YC) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the item
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.empty || status.last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_PT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/ssrp_dpath.sv
module ssrp_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  ssrp_pkg::cfg_t                    cfg,
  input  ssrp_pkg::cmd_t                    cmd,
  output ssrp_pkg::status_t                 status,
  input  logic [ssrp_pkg::COORD_BITS-1:0]   src_x,
  input  logic [ssrp_pkg::COORD_BITS-1:0]   src_y,
  ssrp_point_if.source                      point
);

  localparam int C_W    = ssrp_pkg::C_W;
  localparam int P_W    = ssrp_pkg::P_W;
  localparam int POS_W  = ssrp_pkg::POS_W;
  localparam int CNT_W  = ssrp_pkg::CNT_W;
  localparam int IDX_W  = ssrp_pkg::IDX_W;
  localparam int D_W    = ssrp_pkg::D_W;
  localparam int PROD_W = ssrp_pkg::PROD_W;
  localparam int ACC_W  = ssrp_pkg::ACC_W;
  localparam int OUT_W  = ssrp_pkg::OUT_W;
  localparam int FB     = ssrp_pkg::FRAC_BITS;
  localparam int RS     = ssrp_pkg::ROUND_SHIFT;

  // scaled position: floor((p + half) / 256) - 1
  function automatic logic signed [POS_W-1:0] axis_pos(input logic [P_W-1:0] p);
    logic [P_W-1:0] pr;
    pr = p + P_W'(1 << (FB - 1));
    return $signed({1'b0, pr[P_W-1:FB]}) - $signed(POS_W'(1));
  endfunction

  // fill count: integer scale plus one when a neighbor pixel got skipped, capped at SCALE_INT_LIMIT
  function automatic logic [CNT_W-1:0] axis_cnt(input logic [P_W-1:0] p,
                                               input logic [ssrp_pkg::SCALE_W-1:0] s);
    logic [FB-1:0]                 frac;
    logic [FB-1:0]                 fs;
    logic signed [FB:0]            diff;
    logic [ssrp_pkg::NRAW_W-1:0]   n;
    frac = p[FB-1:0];
    fs   = s[FB-1:0];
    diff = $signed({1'b0, frac}) - $signed({1'b0, fs});
    n    = ssrp_pkg::NRAW_W'(s[ssrp_pkg::SCALE_W-1:FB]);
    if (frac[FB-1] && (diff < $signed({2'b01, {(FB-1){1'b0}}}))) begin
      n = n + ssrp_pkg::NRAW_W'(1);
    end
    if (n > ssrp_pkg::NRAW_W'(ssrp_pkg::SCALE_INT_LIMIT)) begin
      n = ssrp_pkg::NRAW_W'(ssrp_pkg::SCALE_INT_LIMIT);
    end
    return CNT_W'(n);
  endfunction

  // add one half in Q.22, then truncate toward zero
  function automatic logic signed [ACC_W-1:0] round_q(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] q;
    t = a + $signed(ACC_W'(1) << (RS - 1));
    q = t >>> RS;
    if (t[ACC_W-1] && (t[RS-1:0] != '0)) begin
      q = q + $signed(ACC_W'(1));
    end
    return q;
  endfunction

  logic [ssrp_pkg::COORD_BITS-1:0] src_x_r;
  logic [ssrp_pkg::COORD_BITS-1:0] src_y_r;
  logic [P_W-1:0]                  p_x;
  logic [P_W-1:0]                  p_y;
  logic signed [POS_W-1:0]         pos_x;
  logic signed [POS_W-1:0]         pos_y;
  logic [CNT_W-1:0]                nx;
  logic [CNT_W-1:0]                ny;
  logic signed [OUT_W-1:0]         moved_x;
  logic signed [OUT_W-1:0]         moved_y;
  logic [IDX_W-1:0]                i_cnt;
  logic [IDX_W-1:0]                j_cnt;
  logic signed [POS_W-1:0]         pt_x;
  logic signed [POS_W-1:0]         pt_y;
  logic signed [D_W-1:0]           dx;
  logic signed [D_W-1:0]           dy;
  logic signed [ACC_W-1:0]         acc_x;
  logic signed [ACC_W-1:0]         acc_y;
  logic                            out_valid;
  logic signed [OUT_W-1:0]         out_px;
  logic signed [OUT_W-1:0]         out_py;
  logic                            out_pv;
  logic                            out_end;
  logic signed [OUT_W-1:0]         out_mx;
  logic signed [OUT_W-1:0]         out_my;

  logic signed [POS_W-1:0]         pt_x_next;
  logic signed [POS_W-1:0]         pt_y_next;
  logic signed [D_W-1:0]           mul_a;
  logic signed [ssrp_pkg::TRIG_W-1:0] mul_b;
  logic signed [PROD_W-1:0]        prod;
  logic signed [ACC_W-1:0]         prod_ext;
  logic signed [ACC_W-1:0]         base_x;
  logic signed [ACC_W-1:0]         base_y;
  logic                            row_end;

  assign pt_x_next = pos_x - $signed(POS_W'(i_cnt));
  assign pt_y_next = pos_y - $signed(POS_W'(j_cnt));

  assign base_x = $signed({{(ACC_W-ssrp_pkg::CENTER_W-ssrp_pkg::TRIG_FRAC){1'b0}},
                           cfg.center_x, {ssrp_pkg::TRIG_FRAC{1'b0}}});
  assign base_y = $signed({{(ACC_W-ssrp_pkg::CENTER_W-ssrp_pkg::TRIG_FRAC){1'b0}},
                           cfg.center_y, {ssrp_pkg::TRIG_FRAC{1'b0}}});

  // one shared multiplier, one product per cycle
  always_comb begin
    case (cmd.mul_step)
      ssrp_pkg::MUL_XC: begin mul_a = dx; mul_b = cfg.cos_theta; end
      ssrp_pkg::MUL_XS: begin mul_a = dy; mul_b = cfg.sin_theta; end
      ssrp_pkg::MUL_YS: begin mul_a = dx; mul_b = cfg.sin_theta; end
      default:          begin mul_a = dy; mul_b = cfg.cos_theta; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod);

  assign row_end = (CNT_W'(i_cnt) == nx - CNT_W'(1));

  always_comb begin
    status.empty     = (nx == '0) || (ny == '0);
    status.last      = row_end && (CNT_W'(j_cnt) == ny - CNT_W'(1));
    status.slot_free = !out_valid || point.ready;
    status.rot       = cfg.rot;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_x_r <= src_x;
      src_y_r <= src_y;
    end
    if (cmd.scale) begin
      p_x <= P_W'(C_W'(src_x_r) + C_W'(1)) * P_W'(cfg.scale_x);
      p_y <= P_W'(C_W'(src_y_r) + C_W'(1)) * P_W'(cfg.scale_y);
    end
    if (cmd.pos) begin
      pos_x   <= axis_pos(p_x);
      pos_y   <= axis_pos(p_y);
      nx      <= axis_cnt(p_x, cfg.scale_x);
      ny      <= axis_cnt(p_y, cfg.scale_y);
      moved_x <= ssrp_pkg::sat_out(ACC_W'(axis_pos(p_x)) + ACC_W'(cfg.shift_x));
      moved_y <= ssrp_pkg::sat_out(ACC_W'(axis_pos(p_y)) + ACC_W'(cfg.shift_y));
      i_cnt   <= '0;
      j_cnt   <= '0;
    end
    if (cmd.point) begin
      pt_x <= pt_x_next;
      pt_y <= pt_y_next;
      dx   <= D_W'($signed({pt_x_next, {FB{1'b0}}})) - D_W'($signed({1'b0, cfg.center_x}));
      dy   <= D_W'($signed({pt_y_next, {FB{1'b0}}})) - D_W'($signed({1'b0, cfg.center_y}));
    end
    if (cmd.mul) begin
      case (cmd.mul_step)
        ssrp_pkg::MUL_XC: acc_x <= base_x + prod_ext;
        ssrp_pkg::MUL_XS: acc_x <= acc_x - prod_ext;
        ssrp_pkg::MUL_YS: acc_y <= base_y + prod_ext;
        default:          acc_y <= acc_y + prod_ext;
      endcase
    end
    if (cmd.emit) begin
      out_mx <= moved_x;
      out_my <= moved_y;
      if (status.empty) begin
        out_px  <= '0;
        out_py  <= '0;
        out_pv  <= 1'b0;
        out_end <= 1'b1;
      end else begin
        if (cfg.rot) begin
          out_px <= ssrp_pkg::sat_out(round_q(acc_x));
          out_py <= ssrp_pkg::sat_out(round_q(acc_y));
        end else begin
          out_px <= ssrp_pkg::sat_out(ACC_W'(pt_x));
          out_py <= ssrp_pkg::sat_out(ACC_W'(pt_y));
        end
        out_pv  <= 1'b1;
        out_end <= status.last;
        // advance: columns inner, rows outer
        if (row_end) begin
          i_cnt <= '0;
          j_cnt <= j_cnt + IDX_W'(1);
        end else begin
          i_cnt <= i_cnt + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (point.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign point.valid       = out_valid;
  assign point.point_x     = out_px;
  assign point.point_y     = out_py;
  assign point.point_valid = out_pv;
  assign point.run_end     = out_end;
  assign point.moved_x     = out_mx;
  assign point.moved_y     = out_my;

endmodule

>>> src/sprite_scale_rotate_point_fill.sv
// Flow per item: load, scale, position, then for each fill point a point step, four rotation
// multiply steps when rotating, and an emit step; the four rotation products share one
// multiplier, one product per cycle. An item with no fill points emits one empty result.
// A new item is taken only after the last fill point of the previous item is emitted.
// Output stalls hold the emit step; the next item is taken while the last result still waits.
// Reset (rst, synchronous): configuration registers and control state return to their reset values, output empties.
module sprite_scale_rotate_point_fill (
  input  logic          clk,
  input  logic          rst,
  ssrp_cfg_if.sink      cfg,
  ssrp_pixel_if.sink    pixel,
  ssrp_point_if.source  point
);

  ssrp_pkg::cfg_t    regs;
  ssrp_pkg::cmd_t    cmd;
  ssrp_pkg::status_t status;

  ssrp_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ssrp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .status      (status),
    .cmd         (cmd)
  );

  ssrp_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (regs),
    .cmd    (cmd),
    .status (status),
    .src_x  (pixel.src_x),
    .src_y  (pixel.src_y),
    .point  (point)
  );

endmodule

>>> src/ssrp_checker.sv
module ssrp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              pixel_valid,
  input logic                              pixel_ready,
  input logic                              point_ready,
  input logic                              point_valid_q,
  input logic signed [ssrp_pkg::OUT_W-1:0] point_x,
  input logic signed [ssrp_pkg::OUT_W-1:0] point_y,
  input logic                              point_valid,
  input logic                              run_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid_q && !point_ready |=> point_valid_q && $stable(point_x) && $stable(point_y))
    else $error("result dropped or changed while stalled");

  // an item is worked on before the next one is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("input taken on back-to-back cycles");

  // a result without a fill point ends its run and carries a zero point
  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    point_valid_q && !point_valid |-> run_end && point_x == '0 && point_y == '0)
    else $error("empty result malformed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !point_valid_q)
    else $error("output valid after reset");

endmodule

bind sprite_scale_rotate_point_fill ssrp_checker u_ssrp_checker (
  .clk           (clk),
  .rst           (rst),
  .pixel_valid   (pixel.valid),
  .pixel_ready   (pixel.ready),
  .point_ready   (point.ready),
  .point_valid_q (point.valid),
  .point_x       (point.point_x),
  .point_y       (point.point_y),
  .point_valid   (point.point_valid),
  .run_end       (point.run_end)
);

>>> tb/sv/ssrp_point_checker.sv
module ssrp_point_checker
  import ssrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ssrp_cfg_if   cfg,
  ssrp_pixel_if pixel,
  ssrp_point_if point,
  output int    fail_count,
  output int    pending
);

  localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic                    point_valid;
    logic                    run_end;
    logic signed [OUT_W-1:0] moved_x;
    logic signed [OUT_W-1:0] moved_y;
  } fill_point_t;

  fill_point_t fill_q[$];
  int          miss_count = 0;

  logic [SCALE_W-1:0]        scale_xq, scale_yq;
  logic signed [TRIG_W-1:0]  cos_q, sin_q;
  logic [CENTER_W-1:0]       pivot_xq, pivot_yq;
  logic signed [SHIFT_W-1:0] shift_xq, shift_yq;

  assign fail_count = miss_count;

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    if (v < OUT_LO) v = OUT_LO;
    if (v > OUT_HI) v = OUT_HI;
    return OUT_W'(v);
  endfunction

  // Add one half in Q.22, then truncate toward zero
  function automatic longint round_rotated(input longint v);
    longint t;
    t = v + (longint'(1) << (ROUND_SHIFT - 1));
    if (t >= 0) return t >>> ROUND_SHIFT;
    return -((-t) >>> ROUND_SHIFT);
  endfunction

  function automatic void stretch_axis(input logic [COORD_BITS-1:0] src,
                                       input logic [SCALE_W-1:0] s,
                                       output longint pos, output int count);
    longint prod, frac_p, frac_s;
    prod   = (longint'(src) + 1) * longint'(s);
    frac_p = prod & 255;
    frac_s = longint'(s[FRAC_BITS-1:0]);
    count  = int'(s >> FRAC_BITS);
    pos    = ((prod + 128) >>> FRAC_BITS) - 1;
    // neighbor skipped by the rounding also needs a fill
    if (frac_p >= 128 && frac_p - frac_s < 128) count++;
    if (count > SCALE_INT_LIMIT) count = SCALE_INT_LIMIT;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SCALE_X:  scale_xq = value[SCALE_W-1:0];
      REG_SCALE_Y:  scale_yq = value[SCALE_W-1:0];
      REG_COS:      cos_q    = value[TRIG_W-1:0];
      REG_SIN:      sin_q    = value[TRIG_W-1:0];
      REG_CENTER_X: pivot_xq = value[CENTER_W-1:0];
      REG_CENTER_Y: pivot_yq = value[CENTER_W-1:0];
      REG_SHIFT_X:  shift_xq = value[SHIFT_W-1:0];
      REG_SHIFT_Y:  shift_yq = value[SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_fills(input logic [COORD_BITS-1:0] sx_in,
                                        input logic [COORD_BITS-1:0] sy_in);
    longint      x, y, px, py, dx, dy, rx, ry;
    int          nx, ny;
    bit          rotating;
    fill_point_t fp;
    rotating = !(sin_q == '0 && cos_q == COS_ONE);
    stretch_axis(sx_in, scale_xq, x, nx);
    stretch_axis(sy_in, scale_yq, y, ny);
    fp.moved_x = clamp_out(x + longint'(shift_xq));
    fp.moved_y = clamp_out(y + longint'(shift_yq));
    if (nx == 0 || ny == 0) begin
      fp.point_x     = '0;
      fp.point_y     = '0;
      fp.point_valid = 1'b0;
      fp.run_end     = 1'b1;
      fill_q.push_back(fp);
      return;
    end
    for (int j = 0; j < ny; j++) begin
      for (int i = 0; i < nx; i++) begin
        px = x - i;
        py = y - j;
        if (rotating) begin
          dx = px * 256 - longint'(pivot_xq);
          dy = py * 256 - longint'(pivot_yq);
          rx = dx * longint'(cos_q) - dy * longint'(sin_q)
               + (longint'(pivot_xq) << TRIG_FRAC);
          ry = dx * longint'(sin_q) + dy * longint'(cos_q)
               + (longint'(pivot_yq) << TRIG_FRAC);
          px = round_rotated(rx);
          py = round_rotated(ry);
        end
        fp.point_x     = clamp_out(px);
        fp.point_y     = clamp_out(py);
        fp.point_valid = 1'b1;
        fp.run_end     = (j == ny - 1 && i == nx - 1);
        fill_q.push_back(fp);
      end
    end
  endfunction

  function automatic void note_miss(input string what, input fill_point_t want,
                                    input fill_point_t got);
    miss_count++;
    if (miss_count <= 10) begin
      $display("%0t %s: want pt=(%0d,%0d) pv=%0b end=%0b moved=(%0d,%0d)",
               $time, what, want.point_x, want.point_y, want.point_valid,
               want.run_end, want.moved_x, want.moved_y);
      $display("%0t %s: got  pt=(%0d,%0d) pv=%0b end=%0b moved=(%0d,%0d)",
               $time, what, got.point_x, got.point_y, got.point_valid,
               got.run_end, got.moved_x, got.moved_y);
    end
  endfunction

  always @(posedge clk) begin
    fill_point_t got, want;
    if (rst) begin
      fill_q.delete();
      scale_xq = SCALE_RESET;
      scale_yq = SCALE_RESET;
      cos_q    = COS_ONE;
      sin_q    = '0;
      pivot_xq = '0;
      pivot_yq = '0;
      shift_xq = '0;
      shift_yq = '0;
    end else begin
      if (cfg.valid && cfg.ready) store_reg(cfg.index, cfg.data);
      if (pixel.valid && pixel.ready) predict_fills(pixel.src_x, pixel.src_y);
      if (point.valid && point.ready) begin
        got.point_x     = point.point_x;
        got.point_y     = point.point_y;
        got.point_valid = point.point_valid;
        got.run_end     = point.run_end;
        got.moved_x     = point.moved_x;
        got.moved_y     = point.moved_y;
        if (fill_q.size() == 0) begin
          note_miss("unexpected item", '0, got);
        end else begin
          want = fill_q.pop_front();
          if (got !== want) note_miss("mismatch", want, got);
        end
      end
    end
    pending <= fill_q.size();
  end

endmodule

>>> tb/sv/tb_sprite_scale_rotate_point_fill.sv
module tb_sprite_scale_rotate_point_fill;
  import ssrp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssrp_cfg_if   cfg();
  ssrp_pixel_if pixel();
  ssrp_point_if point();

  int fail_count;
  int pending;
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit hold_off_req = 1'b0;

  always #5 clk = ~clk;

  sprite_scale_rotate_point_fill u_top (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .pixel (pixel),
    .point (point)
  );

  ssrp_point_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel      (pixel),
    .point      (point),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    if (!tx_steady) begin
      while ($urandom_range(99) < 36) begin
        pixel.valid <= 1'b0;
        @(negedge clk);
      end
    end
    pixel.valid <= 1'b1;
    pixel.src_x <= x;
    pixel.src_y <= y;
    @(posedge clk);
    while (!pixel.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop the input and wait until every fill point has come out
  task automatic wait_idle();
    pixel.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_transform(input int sx, input int sy, input int cos_v, input int sin_v,
                               input int cx, input int cy, input int hx, input int hy,
                               input bit junk);
    wait_idle();
    // writes past the last register must be dropped
    if (junk) write_reg(CFG_IDX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom));
    write_reg(REG_SCALE_X, CFG_DATA_W'(sx));
    write_reg(REG_SCALE_Y, CFG_DATA_W'(sy));
    write_reg(REG_COS, CFG_DATA_W'(cos_v));
    write_reg(REG_SIN, CFG_DATA_W'(sin_v));
    write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
    write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
    write_reg(REG_SHIFT_X, CFG_DATA_W'(hx));
    write_reg(REG_SHIFT_Y, CFG_DATA_W'(hy));
    cfg.valid <= 1'b0;
  endtask

  function automatic int pick_scale();
    if ($urandom_range(99) < 80) return $urandom_range(0, 767);
    return $urandom_range(768, 2047);
  endfunction

  function automatic int pick_trig(input int mode);
    case (mode)
      1:       return int'($urandom_range(0, 32768)) - 16384;
      2:       return $urandom_range(1) ? 16384 : -16384;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [COORD_BITS-1:0] x, y;
    for (int k = 0; k < count; k++) begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
      if ($urandom_range(9) == 0) x = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(9) == 0) y = $urandom_range(1) ? '1 : '0;
      send_pixel(x, y);
    end
  endtask

  initial begin
    int held;
    point.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // hold off long enough for the block to back up into its input
        point.ready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(negedge clk);
          held++;
        end
        hold_off_req = 1'b0;
      end else begin
        point.ready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin
    int mode, cos_v, sin_v;
    cfg.valid   = 1'b0;
    cfg.index   = REG_SCALE_X;
    cfg.data    = '0;
    pixel.valid = 1'b0;
    pixel.src_x = '0;
    pixel.src_y = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: unit scale, no rotation
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);

    // widest fill blocks, rotation gain near 2.8 so rotated points clamp
    set_transform(2047, 2047, 32767, 32767, 0, 0, 32767, -32768, 1'b0);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    send_pixel(4095, 0);
    set_transform(2047, 2047, -32768, -32768, 20'hfffff, 20'hfffff, -1, 1, 1'b1);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);

    // half scale: a point only where the rounding skips one, half turn with sin zero
    set_transform(128, 128, -16384, 0, 20'h80000, 20'h00100, -32768, 32767, 1'b0);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(4094, 4094);

    // zero scale lands at -1 with no points; barely-off rotation still rotates
    set_transform(0, 0, 16384, 1, 20'h12345, 20'hedcba, 32767, -32768, 1'b1);
    send_pixel(0, 0);
    send_pixel(4095, 4095);

    for (int phase = 0; phase < 6; phase++) begin
      mode = $urandom_range(3);
      cos_v = (mode == 0) ? 16384 : pick_trig(mode);
      sin_v = (mode == 0) ? 0 : pick_trig(mode);
      set_transform(pick_scale(), pick_scale(), cos_v, sin_v,
                    $urandom_range(0, 20'hfffff), $urandom_range(0, 20'hfffff),
                    int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768, $urandom_range(1));
      if (phase == 1) hold_off_req = 1'b1;
      if (phase == 2) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      send_random(24);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sprite_scale_rotate_point_fill");
    end else begin
      $display("FAIL sprite_scale_rotate_point_fill");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL sprite_scale_rotate_point_fill");
    $finish;
  end

endmodule
